>>> rtl/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// No dependencies; the top-level unit uses it by scoped name.
package bfa_pkg;

  localparam int IDX_W          = 12;
  localparam int CNT_W          = 13;
  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;
  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

  typedef enum logic [1:0] {
    MODE_CLAIM   = 2'd0,
    MODE_FIND    = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_MODIFY,
    ST_FIND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] frame_index;
  } req_t;

  typedef struct packed {
    logic             error;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] free_frames;
  } rsp_t;

endpackage

>>> rtl/bfa_map_ram.sv
// Used/free map storage: one write port, one read port, registered read.
// Depends on nothing; instantiated by the top level.
module bfa_map_ram #(
  parameter int Depth = 128,
  parameter int Width = 32,
  parameter int AddrW = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bfa_word_enc.sv
// Lowest-free-frame encoder for one map word (MSB is the lowest frame).
// Frames at or past span are masked off. No package dependencies.
module bfa_word_enc #(
  parameter int WordBits = 32,
  parameter int OffW     = 5,
  parameter int BaseW    = 14
) (
  input  logic [WordBits-1:0] word,
  input  logic [BaseW-1:0]    span,
  output logic                hit,
  output logic [OffW-1:0]     pos
);

  logic [WordBits-1:0] avail;

  always_comb begin
    for (int j = 0; j < WordBits; j++) begin
      avail[j] = !word[WordBits-1-j] && (BaseW'(j) < span);
    end
  end

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int j = WordBits - 1; j >= 0; j--) begin
      if (avail[j]) begin
        hit = 1'b1;
        pos = OffW'(j);
      end
    end
  end

endmodule

>>> rtl/bitmap_frame_allocator_unit.sv
// Bitmap frame allocator: claim, find-lowest-free and release on a word map.
// In-range claim/release: decode, read, modify, done; bad index/mode: decode, done; then idle.
// Find: one map word read per cycle from the RAM port, up to the frame limit.
// Sync reset clears used_count and loads frame_count with 4096, then a clearing pass zeroes
// all MapWords map words (128 by default) with req_stall high; cfg writes are taken throughout.
// Depends on bfa_pkg, bfa_map_ram, bfa_word_enc.
module bitmap_frame_allocator_unit #(
  parameter int MaxFrames = bfa_pkg::MAX_FRAMES_DEF,
  parameter int WordBits  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bfa_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bfa_pkg::rsp_t             rsp
);

  localparam int MapWords   = (MaxFrames + WordBits - 1) / WordBits;
  localparam int AddrW      = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int OffW       = $clog2(WordBits);
  localparam int IdxW       = bfa_pkg::IDX_W;
  localparam int CntW       = bfa_pkg::CNT_W;
  localparam int BaseW      = CntW + 1;
  localparam int RecipShift = IdxW + OffW;
  localparam int Recip      = ((1 << RecipShift) + WordBits - 1) / WordBits;
  localparam int ProdW      = 2 * IdxW + 2;

  bfa_pkg::state_t state, state_next;

  logic [CntW-1:0]     frame_count;
  logic [CntW-1:0]     used_count;
  logic [AddrW-1:0]    clr_addr;
  logic [1:0]          req_mode;
  logic [IdxW-1:0]     req_idx;
  logic [IdxW-1:0]     q_idx;
  logic [OffW-1:0]     bit_off;
  logic [AddrW-1:0]    scan_addr;
  logic [BaseW-1:0]    scan_base;
  logic                chk_valid;
  logic [BaseW-1:0]    chk_base;
  logic                res_err;
  logic [IdxW-1:0]     res_idx;

  logic [CntW-1:0]     lim;
  logic                in_range;
  logic [ProdW-1:0]    prod;
  logic [IdxW-1:0]     quot;
  logic [IdxW-1:0]     word_base;
  logic [OffW-1:0]     off_now;
  logic [WordBits-1:0] bit_mask;
  logic                cur_used;
  logic                is_claim;
  logic                is_release;
  logic                is_find;
  logic                claim_ok;
  logic                rel_ok;
  logic                issue;
  logic                enc_hit;
  logic [OffW-1:0]     enc_pos;
  logic                find_hit;
  logic                find_miss;
  logic [CntW-1:0]     free_now;
  logic                accept;
  logic                rsp_load;

  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [WordBits-1:0] wr_data;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [WordBits-1:0] rd_data;

  assign lim = (32'(frame_count) > 32'(MaxFrames)) ? CntW'(MaxFrames) : frame_count;
  assign in_range = {1'b0, req_idx} < lim;
  assign is_claim   = req_mode == bfa_pkg::MODE_CLAIM;
  assign is_release = req_mode == bfa_pkg::MODE_RELEASE;
  assign is_find    = req_mode == bfa_pkg::MODE_FIND;

  // word = idx / WordBits via reciprocal, exact over the index range
  assign prod      = ProdW'(req_idx) * ProdW'(Recip);
  assign quot      = IdxW'(prod >> RecipShift);
  assign word_base = IdxW'(q_idx * IdxW'(WordBits));
  assign off_now   = OffW'(req_idx - word_base);

  assign bit_mask = {1'b1, {(WordBits-1){1'b0}}} >> bit_off;
  assign cur_used = |(rd_data & bit_mask);
  assign claim_ok = is_claim && !cur_used;
  assign rel_ok   = is_release && cur_used;

  assign issue     = (state == bfa_pkg::ST_FIND) && (scan_base < {1'b0, lim});
  assign find_hit  = chk_valid && enc_hit;
  assign find_miss = !chk_valid && (scan_base >= {1'b0, lim});

  assign free_now = (lim > used_count) ? CntW'(lim - used_count) : '0;

  bfa_word_enc #(
    .WordBits (WordBits),
    .OffW     (OffW),
    .BaseW    (BaseW)
  ) u_enc (
    .word (rd_data),
    .span (BaseW'({1'b0, lim} - chk_base)),
    .hit  (enc_hit),
    .pos  (enc_pos)
  );

  bfa_map_ram #(
    .Depth (MapWords),
    .Width (WordBits),
    .AddrW (AddrW)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfa_pkg::ST_CLEAR: begin
        if (clr_addr == AddrW'(MapWords - 1)) state_next = bfa_pkg::ST_IDLE;
      end
      bfa_pkg::ST_IDLE: begin
        if (req_valid) state_next = bfa_pkg::ST_DECODE;
      end
      bfa_pkg::ST_DECODE: begin
        if (is_find) begin
          state_next = bfa_pkg::ST_FIND;
        end else if ((is_claim || is_release) && in_range) begin
          state_next = bfa_pkg::ST_READ;
        end else begin
          state_next = bfa_pkg::ST_DONE;
        end
      end
      bfa_pkg::ST_READ:   state_next = bfa_pkg::ST_MODIFY;
      bfa_pkg::ST_MODIFY: state_next = bfa_pkg::ST_DONE;
      bfa_pkg::ST_FIND: begin
        if (find_hit || find_miss) state_next = bfa_pkg::ST_DONE;
      end
      bfa_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = bfa_pkg::ST_IDLE;
      end
      default: state_next = bfa_pkg::ST_IDLE;
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    req_stall = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = AddrW'(q_idx);
    wr_data   = claim_ok ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    rd_en     = 1'b0;
    rd_addr   = scan_addr;
    rsp_load  = 1'b0;
    unique case (state)
      bfa_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      bfa_pkg::ST_IDLE:   req_stall = 1'b0;
      bfa_pkg::ST_DECODE: ;
      bfa_pkg::ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = AddrW'(q_idx);
      end
      bfa_pkg::ST_MODIFY: wr_en = claim_ok || rel_ok;
      bfa_pkg::ST_FIND:   rd_en = issue;
      bfa_pkg::ST_DONE:   rsp_load = !rsp_valid || !rsp_stall;
      default: ;
    endcase
  end

  assign accept = req_valid && !req_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bfa_pkg::ST_CLEAR;
      clr_addr    <= '0;
      frame_count <= bfa_pkg::FRAME_COUNT_RST;
      used_count  <= '0;
      rsp_valid   <= 1'b0;
      chk_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) frame_count <= cfg_wdata;
      if (state == bfa_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == bfa_pkg::ST_MODIFY) begin
        if (claim_ok) begin
          used_count <= used_count + 1'b1;
        end else if (rel_ok && used_count != '0) begin
          used_count <= used_count - 1'b1;
        end
      end
      if (state == bfa_pkg::ST_DECODE) begin
        chk_valid <= 1'b0;
      end else if (state == bfa_pkg::ST_FIND) begin
        chk_valid <= issue;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= req.mode;
      req_idx  <= req.frame_index;
    end
    if (state == bfa_pkg::ST_DECODE) begin
      q_idx     <= quot;
      scan_addr <= '0;
      scan_base <= '0;
      res_err   <= 1'b1;
      res_idx   <= is_find ? '0 : req_idx;
    end
    if (state == bfa_pkg::ST_READ) bit_off <= off_now;
    if (state == bfa_pkg::ST_MODIFY) res_err <= !(claim_ok || rel_ok);
    if (state == bfa_pkg::ST_FIND) begin
      chk_base <= scan_base;
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
        scan_base <= scan_base + BaseW'(WordBits);
      end
      if (find_hit) begin
        res_err <= 1'b0;
        res_idx <= IdxW'(chk_base + BaseW'(enc_pos));
      end
    end
    if (rsp_load) begin
      rsp.error       <= res_err;
      rsp.found_index <= res_idx;
      rsp.free_frames <= free_now;
    end
  end

  a_wr_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == bfa_pkg::ST_CLEAR || state == bfa_pkg::ST_MODIFY))
    else $error("map written outside clear pass or modify");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(used_count) |-> ($past(state) == bfa_pkg::ST_MODIFY || $past(rst)))
    else $error("used count changed outside modify");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == bfa_pkg::ST_DONE)
    else $error("response raised without a finished request");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == bfa_pkg::ST_FIND |-> scan_base <= BaseW'({1'b0, lim}) + BaseW'(WordBits))
    else $error("find scan ran past the frame limit");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == bfa_pkg::ST_DECODE |-> $past(state) == bfa_pkg::ST_IDLE)
    else $error("request decoded without acceptance in idle");

endmodule
